### hdl/i2cbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types, constants and helper functions of the I2C bit-level sequencer.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    // Default parameter values
    localparam int UNIT_COUNTER_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF        = 4;

    // Stream payload widths (fields packed from bit 0, padded to bytes)
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // Configuration registers
    localparam int              CFG_DATA_W      = 16;
    localparam logic            CFG_UNIT_TICKS  = 1'b0;
    localparam logic            CFG_ACK_LIMIT   = 1'b1;
    localparam logic [15:0]     UNIT_TICKS_RST  = 16'd50;
    localparam logic [7:0]      ACK_LIMIT_RST   = 8'd10;

    // Command opcodes
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_ACK   = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_STOP,
        PH_WRITE,
        PH_READ,
        PH_ACK
    } t_phase;

    // Step numbers with a special meaning
    localparam logic [5:0] ACK_SCL_HIGH_STEP  = 6'd4;
    localparam logic [5:0] ACK_POLL_STEP      = 6'd5;
    localparam logic [5:0] ACK_RELEASE_STEP   = 6'd6;
    localparam logic [5:0] WRITE_BITS_END     = 6'd40;
    localparam logic [5:0] WRITE_SDA_FREE     = 6'd41;
    localparam logic [5:0] READ_LAST_BIT_STEP = 6'd17;

    // Slots inside one five-unit write bit
    localparam logic [2:0] SLOT_SCL_LOW  = 3'd0;
    localparam logic [2:0] SLOT_DATA     = 3'd1;
    localparam logic [2:0] SLOT_SCL_HIGH = 3'd4;

    // Classified command passed from front to back
    typedef struct packed {
        logic       start_ok;   // valid command with a legal opcode
        t_phase     phase;      // sequence it starts
        logic [7:0] tx_byte;
        logic       sda_in;
    } t_cmd;

    // Pin levels and shift register touched when a step begins
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] shift;
    } t_pins;

    function automatic logic [5:0] seq_length(input t_phase p);
        case (p)
            PH_START: return 6'd3;
            PH_STOP:  return 6'd3;
            PH_WRITE: return 6'd42;
            PH_READ:  return 6'd19;
            PH_ACK:   return 6'd11;
            default:  return 6'd1;
        endcase
    endfunction

    // Position within a write bit (step mod 5), valid for steps below 40
    function automatic logic [2:0] write_slot(input logic [5:0] s);
        logic [5:0] r;
        r = s;
        if (r >= 6'd20) r = r - 6'd20;
        if (r >= 6'd10) r = r - 6'd10;
        if (r >= 6'd5)  r = r - 6'd5;
        return r[2:0];
    endfunction

endpackage

### hdl/i2cbm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_front
// Input stage: takes one item per cycle unless its output is stalled, decodes the opcode, registers it.
// ----------------------------------------------------------------------------
module i2cbm_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [i2cbm_pkg::IN_DATA_W-1:0] i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output i2cbm_pkg::t_cmd                o_cmd
);

    logic            r_valid;
    logic            n_valid;
    i2cbm_pkg::t_cmd r_cmd;
    i2cbm_pkg::t_cmd n_cmd;
    logic [2:0]      w_op;

    assign w_op    = i_data[3:1];
    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_cmd.tx_byte  = i_data[11:4];
        n_cmd.sda_in   = i_data[12];
        n_cmd.start_ok = i_data[0];
        case (w_op)
            i2cbm_pkg::OP_START: n_cmd.phase = i2cbm_pkg::PH_START;
            i2cbm_pkg::OP_STOP:  n_cmd.phase = i2cbm_pkg::PH_STOP;
            i2cbm_pkg::OP_WRITE: n_cmd.phase = i2cbm_pkg::PH_WRITE;
            i2cbm_pkg::OP_READ:  n_cmd.phase = i2cbm_pkg::PH_READ;
            i2cbm_pkg::OP_ACK:   n_cmd.phase = i2cbm_pkg::PH_ACK;
            default: begin
                // undefined opcodes start no sequence: start_ok is cleared
                n_cmd.phase    = i2cbm_pkg::PH_IDLE;
                n_cmd.start_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

### hdl/i2cbm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_queue
// Small FIFO of decoded commands between front and back.
// ----------------------------------------------------------------------------
module i2cbm_queue #(
    parameter int DEPTH = i2cbm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  i2cbm_pkg::t_cmd i_push_cmd,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output i2cbm_pkg::t_cmd o_pop_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    i2cbm_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [AW-1:0]   n_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_cmd    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

### hdl/i2cbm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_back
// Pin sequencer: advances the bus state one tick per command item and
// registers the result for the output channel.
// ----------------------------------------------------------------------------
module i2cbm_back #(
    parameter int UNIT_COUNTER_WIDTH = i2cbm_pkg::UNIT_COUNTER_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  i2cbm_pkg::t_cmd                  i_cmd,
    input  logic [15:0]                      i_unit_ticks,
    input  logic [7:0]                       i_ack_poll_limit,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [i2cbm_pkg::OUT_DATA_W-1:0] o_data
);

    localparam int UW = UNIT_COUNTER_WIDTH;
    localparam logic [32:0] CMAX = (33'd1 << UW) - 33'd1;

    i2cbm_pkg::t_phase r_phase;
    i2cbm_pkg::t_phase n_phase;
    logic [UW-1:0]     r_uc;
    logic [UW-1:0]     n_uc;
    logic [5:0]        r_step;
    logic [5:0]        n_step;
    logic [7:0]        r_poll;
    logic [7:0]        n_poll;
    i2cbm_pkg::t_pins  r_pins;
    i2cbm_pkg::t_pins  n_pins;
    logic [7:0]        r_rx;
    logic [7:0]        n_rx;
    logic              r_timeout;
    logic              n_timeout;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [i2cbm_pkg::OUT_DATA_W-1:0] r_out;
    logic [i2cbm_pkg::OUT_DATA_W-1:0] n_out;

    logic              w_take;
    logic              w_idle;
    logic [UW-1:0]     w_eff;
    logic [UW-1:0]     w_uc_inc;
    logic              w_unit_done;
    logic [5:0]        w_step_inc;
    logic              w_seq_end;
    logic              w_ack_wait;
    logic [7:0]        w_poll_inc;
    logic              w_poll_hit;
    logic              w_cmd_end;
    logic              w_done;

    function automatic i2cbm_pkg::t_pins enter_step(
        input i2cbm_pkg::t_phase p,
        input logic [5:0]        s,
        input i2cbm_pkg::t_pins  cur,
        input logic              sda_in
    );
        i2cbm_pkg::t_pins nx;
        logic [2:0]       slot;
        nx   = cur;
        slot = i2cbm_pkg::write_slot(s);
        case (p)
            i2cbm_pkg::PH_START: begin
                if (s == 6'd0)      nx.sda = 1'b1;
                else if (s == 6'd1) nx.scl = 1'b1;
                else if (s == 6'd2) nx.sda = 1'b0;
            end
            i2cbm_pkg::PH_STOP: begin
                if (s == 6'd0)      nx.sda = 1'b0;
                else if (s == 6'd1) nx.scl = 1'b1;
                else if (s == 6'd2) nx.sda = 1'b1;
            end
            i2cbm_pkg::PH_WRITE: begin
                if (s < i2cbm_pkg::WRITE_BITS_END) begin
                    case (slot)
                        i2cbm_pkg::SLOT_SCL_LOW:  nx.scl = 1'b0;
                        i2cbm_pkg::SLOT_DATA: begin
                            nx.sda   = cur.shift[7];
                            nx.shift = {cur.shift[6:0], 1'b0};
                        end
                        i2cbm_pkg::SLOT_SCL_HIGH: nx.scl = 1'b1;
                        default: ;
                    endcase
                end else if (s == i2cbm_pkg::WRITE_BITS_END) begin
                    nx.scl = 1'b0;
                end else if (s == i2cbm_pkg::WRITE_SDA_FREE) begin
                    nx.sda = 1'b1;
                end
            end
            i2cbm_pkg::PH_READ: begin
                if (s == 6'd0) begin
                    nx.scl = 1'b0;
                end else if (s == 6'd1) begin
                    nx.sda = 1'b1;
                end else if (s <= i2cbm_pkg::READ_LAST_BIT_STEP) begin
                    if (!s[0]) begin
                        nx.scl = 1'b1;
                    end else begin
                        nx.shift = {cur.shift[6:0], sda_in};
                        nx.scl   = 1'b0;
                    end
                end
            end
            i2cbm_pkg::PH_ACK: begin
                if (s == i2cbm_pkg::ACK_SCL_HIGH_STEP)     nx.scl = 1'b1;
                else if (s == i2cbm_pkg::ACK_RELEASE_STEP) nx.scl = 1'b0;
            end
            default: ;
        endcase
        return nx;
    endfunction

    assign o_ready = !r_out_valid || i_ready;
    assign w_take  = i_valid && o_ready;
    assign w_idle  = (r_phase == i2cbm_pkg::PH_IDLE);

    // Unit timing and step bookkeeping
    always_comb begin
        logic [32:0] ut;
        ut          = 33'(i_unit_ticks);
        if (i_unit_ticks == '0) begin
            w_eff = UW'(1);
        end else if (ut > CMAX) begin
            w_eff = CMAX[UW-1:0];
        end else begin
            w_eff = ut[UW-1:0];
        end
        w_uc_inc    = r_uc + UW'(1);
        w_unit_done = (w_uc_inc >= w_eff);
        w_step_inc  = r_step + 6'd1;
        w_seq_end   = (w_step_inc >= i2cbm_pkg::seq_length(r_phase));
        w_ack_wait  = (r_phase == i2cbm_pkg::PH_ACK) &&
                      ((r_step == i2cbm_pkg::ACK_SCL_HIGH_STEP) ||
                       (r_step == i2cbm_pkg::ACK_POLL_STEP));
        w_poll_inc  = r_poll + 8'd1;
        w_poll_hit  = (r_step == i2cbm_pkg::ACK_POLL_STEP) &&
                      (w_poll_inc == i_ack_poll_limit);
        w_cmd_end   = !w_idle && w_unit_done &&
                      (w_ack_wait ? w_poll_hit : w_seq_end);
        w_done      = w_cmd_end;
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (w_take) begin
            if (w_idle) begin
                if (i_cmd.start_ok) begin
                    n_phase = i_cmd.phase;
                end
            end else if (w_cmd_end) begin
                n_phase = i2cbm_pkg::PH_IDLE;
            end
        end
    end

    // Counters, pins and captured data
    always_comb begin
        i2cbm_pkg::t_pins seed;
        n_uc      = r_uc;
        n_step    = r_step;
        n_poll    = r_poll;
        n_pins    = r_pins;
        n_rx      = r_rx;
        n_timeout = r_timeout;
        seed      = r_pins;
        if (w_take) begin
            if (w_idle) begin
                if (i_cmd.start_ok) begin
                    n_uc       = '0;
                    n_step     = '0;
                    n_poll     = '0;
                    n_timeout  = 1'b0;
                    seed.shift = (i_cmd.phase == i2cbm_pkg::PH_WRITE) ? i_cmd.tx_byte : 8'd0;
                    n_pins     = enter_step(i_cmd.phase, 6'd0, seed, i_cmd.sda_in);
                end
            end else begin
                n_uc = w_uc_inc;
                if (w_unit_done) begin
                    n_uc = '0;
                    if (w_ack_wait) begin
                        n_poll = (r_step == i2cbm_pkg::ACK_SCL_HIGH_STEP) ? 8'd0 : w_poll_inc;
                        if (w_poll_hit) begin
                            // poll limit reached: give up, SCL left high
                            n_timeout = 1'b1;
                            n_step    = '0;
                        end else if (i_cmd.sda_in && (n_poll < i_ack_poll_limit)) begin
                            n_step = i2cbm_pkg::ACK_POLL_STEP;
                        end else begin
                            n_step     = i2cbm_pkg::ACK_RELEASE_STEP;
                            n_pins.scl = 1'b0;
                        end
                    end else if (w_seq_end) begin
                        n_step = '0;
                        if (r_phase == i2cbm_pkg::PH_READ) begin
                            n_rx = r_pins.shift;
                        end
                    end else begin
                        n_step = w_step_inc;
                        n_pins = enter_step(r_phase, w_step_inc, r_pins, i_cmd.sda_in);
                    end
                end
            end
        end
    end

    // Result register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (o_ready) begin
            n_out_valid = i_valid;
        end
        if (w_take) begin
            n_out = {3'b000, n_timeout, n_rx, w_done,
                     (n_phase != i2cbm_pkg::PH_IDLE), n_pins.sda, n_pins.scl};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2cbm_pkg::PH_IDLE;
            r_uc        <= '0;
            r_step      <= '0;
            r_poll      <= '0;
            r_pins      <= '{scl: 1'b1, sda: 1'b1, shift: 8'd0};
            r_rx        <= '0;
            r_timeout   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_uc        <= n_uc;
            r_step      <= n_step;
            r_poll      <= n_poll;
            r_pins      <= n_pins;
            r_rx        <= n_rx;
            r_timeout   <= n_timeout;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### hdl/i2c_bitbang_master_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bitbang_master_sequencer_unit
// Bit-level I2C master: one input item is one bus tick, one result per item.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                Payload
// s_axis    in   i_s_axis_tvalid/o_tready tdata: cmd_valid, operation, tx_byte, sda_in
// m_axis    out  o_m_axis_tvalid/i_tready tdata: scl, sda_out, busy_res, done_res,
//                                               rx_byte, ack_timeout
// cfg       in   i_cfg_valid/o_cfg_ready  index 0 unit_ticks, 1 ack_poll_limit
//
// Cycles: one item per clock sustained unless stalled; the bus state is
//   computed combinationally from one item and registered. Items pass the
//   input register, the command queue and the result register in order.
// Reset: synchronous, active low; SCL and SDA come up released, registers
//   take their defaults (50 ticks per unit, 10 poll units).
// Stalls: the front keeps accepting until the queue and its own register are
//   full; the back advances only when its result register can be emptied.
//
module i2c_bitbang_master_sequencer_unit #(
    parameter int UNIT_COUNTER_WIDTH = i2cbm_pkg::UNIT_COUNTER_WIDTH_DEF,
    parameter int QUEUE_DEPTH        = i2cbm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [0] cmd_valid, [3:1] operation, [11:4] tx_byte, [12] sda_in, [15:13] zero
    input  logic [i2cbm_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // result items
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] scl, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rx_byte,
    // [12] ack_timeout, [15:13] zero
    output logic [i2cbm_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [i2cbm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic            w_f_valid;
    logic            w_f_ready;
    i2cbm_pkg::t_cmd w_f_cmd;
    logic            w_q_valid;
    logic            w_q_ready;
    i2cbm_pkg::t_cmd w_q_cmd;

    logic [15:0]     r_unit_ticks;
    logic [7:0]      r_ack_limit;

    // Registers are always writable; writes belong where no item is in flight.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks <= i2cbm_pkg::UNIT_TICKS_RST;
            r_ack_limit  <= i2cbm_pkg::ACK_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                i2cbm_pkg::CFG_UNIT_TICKS: r_unit_ticks <= i_cfg_data;
                i2cbm_pkg::CFG_ACK_LIMIT:  r_ack_limit  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Front: decode and register the item
    i2cbm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_cmd   (w_f_cmd)
    );

    // Decoupling queue
    i2cbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_cmd   (w_f_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_cmd    (w_q_cmd)
    );

    // Back: pin sequencer and result register
    i2cbm_back #(
        .UNIT_COUNTER_WIDTH (UNIT_COUNTER_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_q_valid),
        .o_ready          (w_q_ready),
        .i_cmd            (w_q_cmd),
        .i_unit_ticks     (r_unit_ticks),
        .i_ack_poll_limit (r_ack_limit),
        .o_valid          (o_m_axis_tvalid),
        .i_ready          (i_m_axis_tready),
        .o_data           (o_m_axis_tdata)
    );

endmodule

### hdl/i2cbm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cbm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    logic w_busy;
    logic w_done;
    logic w_timeout;

    assign w_busy    = o_m_axis_tdata[2];
    assign w_done    = o_m_axis_tdata[3];
    assign w_timeout = o_m_axis_tdata[12];

    // no result may appear straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // a finishing command leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_done) |-> !w_busy)
        else $error("done reported while still busy");

    // the timeout flag only survives while no command runs
    a_timeout_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_timeout) |-> !w_busy)
        else $error("timeout flag set during a command");

endmodule

bind i2c_bitbang_master_sequencer_unit i2cbm_checker u_i2cbm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
